/* rtl/core/aipu_pkg.sv */
// Shared types and constants for the active Ising particle update block.
`timescale 1ns / 1ps
package aipu_pkg;

	localparam int COORD_W = 7;
	localparam int MAG_W   = 12;
	localparam int DENS_W  = 11;
	localparam int WIND_W  = 16;
	localparam int RATE_W  = 33;
	localparam int THR_W   = 36;

	localparam int unsigned LOG2E_Q16 = 94548;
	localparam int unsigned POLY_C1   = 43043;
	localparam int unsigned POLY_C2   = 22493;

	localparam logic OP_PLACE  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ACT_PLACED      = 3'd0,
		ACT_NONE        = 3'd1,
		ACT_FLIP        = 3'd2,
		ACT_HOP_AGAINST = 3'd3,
		ACT_HOP_ALONG   = 3'd4,
		ACT_UP          = 3'd5,
		ACT_DOWN        = 3'd6
	} action_t;

	typedef struct packed {
		logic        opcode;
		logic [9:0]  particle_index;
		logic [5:0]  place_x;
		logic [5:0]  place_y;
		logic        place_spin;
		logic [31:0] uniform_draw;
	} item_t;

	typedef struct packed {
		action_t            action;
		logic [5:0]         new_x;
		logic [5:0]         new_y;
		logic               new_spin;
		logic signed [15:0] winding_x;
		logic signed [15:0] winding_y;
		logic signed [11:0] total_magnetization;
	} result_t;

	typedef struct packed {
		logic [6:0]  lattice_width;
		logic [6:0]  lattice_height;
		logic [31:0] flip_rate_dt;
		logic [15:0] coupling;
		logic [31:0] diffusion_dt;
		logic [31:0] drive_dt;
	} cfg_t;

endpackage

/* rtl/core/active_ising_particle_update_top.sv */
// Top level of the active Ising particle update block.
// After reset the block clears its site store, one site a cycle, all
// MAX_WIDTH*MAX_HEIGHT sites (4096 at the defaults) with busy high. An item
// is taken when start is high and busy is low. Busy then stays high while
// the item is worked on, with one modulo step at a time of index and
// coordinates. An update spends most of its time in the flip-rate unit: its
// serial divider forms coupling*|m|/rho bit by bit, then come the polynomial
// and scaling multiplies, then the write-back of the old site unless nothing
// changes and, on a move, the read-modify-write of the new site. The result
// appears in the same cycle that busy falls, for one cycle with done high; a
// new item can be taken in that same cycle. The receiver cannot stall the
// block and must take the result then, since nothing holds it.
`timescale 1ns / 1ps
module active_ising_particle_update_top #(
	parameter int MAX_PARTICLES = 1024,
	parameter int MAX_WIDTH     = 64,
	parameter int MAX_HEIGHT    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aipu_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output aipu_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	aipu_pkg::cfg_t cfg;

	aipu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aipu_core #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cfg    (cfg),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule

/* rtl/core/aipu_cfg.sv */
// APB-style configuration register file.
`timescale 1ns / 1ps
module aipu_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output aipu_pkg::cfg_t     cfg
);

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_FLIP     = 3'd2,
		REG_COUPLING = 3'd3,
		REG_DIFF     = 3'd4,
		REG_DRIVE    = 3'd5
	} reg_idx_t;

	aipu_pkg::cfg_t cfg_q;
	logic           wr;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lattice_width  <= 7'd64;
			cfg_q.lattice_height <= 7'd64;
			cfg_q.flip_rate_dt   <= '0;
			cfg_q.coupling       <= '0;
			cfg_q.diffusion_dt   <= '0;
			cfg_q.drive_dt       <= '0;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:    cfg_q.lattice_width  <= pwdata[6:0];
				REG_HEIGHT:   cfg_q.lattice_height <= pwdata[6:0];
				REG_FLIP:     cfg_q.flip_rate_dt   <= pwdata;
				REG_COUPLING: cfg_q.coupling       <= pwdata[15:0];
				REG_DIFF:     cfg_q.diffusion_dt   <= pwdata;
				REG_DRIVE:    cfg_q.drive_dt       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:    prdata = {25'd0, cfg_q.lattice_width};
			REG_HEIGHT:   prdata = {25'd0, cfg_q.lattice_height};
			REG_FLIP:     prdata = cfg_q.flip_rate_dt;
			REG_COUPLING: prdata = {16'd0, cfg_q.coupling};
			REG_DIFF:     prdata = cfg_q.diffusion_dt;
			REG_DRIVE:    prdata = cfg_q.drive_dt;
			default:      prdata = '0;
		endcase
	end

endmodule

/* rtl/core/aipu_rate.sv */
// Flip threshold unit: serial divider, 2^x polynomial and scaling.
`timescale 1ns / 1ps
module aipu_rate (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [11:0]           m,
	input  logic [10:0]                  rho,
	input  logic                         spin_up,
	input  aipu_pkg::cfg_t               cfg,
	output logic                         done,
	output logic [aipu_pkg::RATE_W-1:0]  t1
);

	typedef enum logic [2:0] {
		R_IDLE, R_NUM, R_DIV, R_EXP, R_POLY1, R_POLY2, R_PROD, R_SHIFT
	} rstate_t;

	rstate_t                      state_q;
	logic [11:0]                  mag_q;
	logic [10:0]                  rho_q;
	logic [10:0]                  rem_q;
	logic [27:0]                  num_q;
	logic [4:0]                   cnt_q;
	logic                         neg_q;
	logic [32:0]                  y_q;
	logic [16:0]                  g_q;
	logic [15:0]                  h1_q;
	logic [4:0]                   k_q;
	logic [17:0]                  p_q;
	logic [49:0]                  prod_q;
	logic [aipu_pkg::RATE_W-1:0]  t1_q;
	logic                         done_q;

	logic [11:0] rem_sh;
	logic        ge;
	logic [15:0] a;
	logic [16:0] g;
	logic [63:0] scaled;
	logic [63:0] prod_ext;

	assign rem_sh = {rem_q, num_q[27]};
	assign ge     = rem_sh >= {1'b0, rho_q};
	assign a      = (rho_q == '0) ? 16'd0 : ((|num_q[27:16]) ? 16'hFFFF : num_q[15:0]);
	assign g      = neg_q ? (17'd65536 - {1'b0, y_q[27:12]}) : {1'b0, y_q[27:12]};
	assign prod_ext = {14'd0, prod_q};

	always_comb begin
		if (neg_q)
			scaled = prod_ext >> (6'd17 + {1'b0, k_q});
		else if (k_q >= 5'd16)
			scaled = prod_ext << (k_q - 5'd16);
		else
			scaled = prod_ext >> (5'd16 - k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			mag_q   <= '0;
			rho_q   <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			y_q     <= '0;
			g_q     <= '0;
			h1_q    <= '0;
			k_q     <= '0;
			p_q     <= '0;
			prod_q  <= '0;
			t1_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						mag_q   <= m[11] ? 12'(-m) : 12'(m);
						rho_q   <= rho;
						neg_q   <= (spin_up && !m[11] && m != 12'sd0) || (!spin_up && m[11]);
						state_q <= R_NUM;
					end
				end
				R_NUM: begin
					num_q   <= 28'(cfg.coupling) * 28'(mag_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= R_DIV;
				end
				R_DIV: begin
					rem_q <= ge ? 11'(rem_sh - {1'b0, rho_q}) : rem_sh[10:0];
					num_q <= {num_q[26:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd27)
						state_q <= R_EXP;
				end
				R_EXP: begin
					y_q     <= 33'(a) * 33'(aipu_pkg::LOG2E_Q16);
					state_q <= R_POLY1;
				end
				R_POLY1: begin
					g_q     <= g;
					h1_q    <= 16'((32'(g) * 32'(aipu_pkg::POLY_C2)) >> 16);
					k_q     <= y_q[32:28];
					state_q <= R_POLY2;
				end
				R_POLY2: begin
					p_q <= 18'd65536 + 18'((34'(g_q)
						* 34'(17'(aipu_pkg::POLY_C1) + 17'(h1_q))) >> 16);
					state_q <= R_PROD;
				end
				R_PROD: begin
					prod_q  <= 50'(cfg.flip_rate_dt) * 50'(p_q);
					state_q <= R_SHIFT;
				end
				R_SHIFT: begin
					t1_q    <= (scaled > 64'h1_0000_0000) ? 33'h1_0000_0000 : scaled[32:0];
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign t1   = t1_q;

endmodule

/* rtl/core/aipu_core.sv */
// Sequencer with particle and site memories; read, modify, write back.
`timescale 1ns / 1ps
module aipu_core #(
	parameter int MAX_PARTICLES = 1024,
	parameter int MAX_WIDTH     = 64,
	parameter int MAX_HEIGHT    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aipu_pkg::item_t   item,
	input  aipu_pkg::cfg_t    cfg,
	output logic              busy,
	output logic              done,
	output aipu_pkg::result_t result
);

	localparam int SITES  = MAX_WIDTH * MAX_HEIGHT;
	localparam int SA_W   = $clog2(SITES);
	localparam int PA_W   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int IDXR_W = (PA_W > 10) ? PA_W : 10;
	localparam int CW     = aipu_pkg::COORD_W;

	typedef struct packed {
		logic [CW-1:0]      x;
		logic [CW-1:0]      y;
		logic               spin;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
	} pent_t;

	typedef struct packed {
		logic signed [11:0] mag;
		logic [10:0]        dens;
	} site_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_IDX, S_PRD, S_PLAT, S_MOD, S_SRD, S_SLAT,
		S_RATE, S_DECIDE, S_MOVE, S_NRD, S_NLAT, S_FIN
	} state_t;

	pent_t pmem [MAX_PARTICLES];
	site_t smem [SITES];

	state_t             state_q;
	logic [SA_W-1:0]    clr_q;
	aipu_pkg::item_t    item_q;
	logic [IDXR_W-1:0]  idx_q;
	logic [CW-1:0]      x_q, y_q, nx_q, ny_q;
	logic               up_q;
	logic signed [15:0] wx_q, wy_q;
	logic signed [11:0] m_q;
	logic [10:0]        rho_q;
	logic signed [11:0] total_q;
	aipu_pkg::action_t  act_q;
	pent_t              prd_q;
	site_t              srd_q;
	logic               done_q;
	aipu_pkg::result_t  result_q;
	logic [34:0]        off1_q, off2_q, off3_q, off4_q;

	logic [CW-1:0]      w_eff, h_eff;
	logic [PA_W-1:0]    paddr;
	logic               pwe;
	pent_t              pwdata;
	logic               swe;
	logic [SA_W-1:0]    swaddr, sraddr;
	site_t              swdata;
	logic signed [11:0] sv, sv2;
	logic               rate_start, rate_done;
	logic [aipu_pkg::RATE_W-1:0] t1;
	logic [aipu_pkg::THR_W-1:0]  t1e, draw_e;
	aipu_pkg::action_t  act_d;
	logic               dir_plus;

	function automatic logic [SA_W-1:0] site_of(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
		return SA_W'(32'(cy) * MAX_WIDTH + 32'(cx));
	endfunction

	function automatic logic signed [15:0] sat_inc(input logic signed [15:0] v);
		return (v == 16'sh7FFF) ? v : v + 16'sd1;
	endfunction

	function automatic logic signed [15:0] sat_dec(input logic signed [15:0] v);
		return (v == -16'sh8000) ? v : v - 16'sd1;
	endfunction

	assign w_eff = (cfg.lattice_width == '0) ? 7'd1 :
		((32'(cfg.lattice_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg.lattice_width);
	assign h_eff = (cfg.lattice_height == '0) ? 7'd1 :
		((32'(cfg.lattice_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg.lattice_height);

	assign sv  = up_q ? 12'sd1 : -12'sd1;
	assign sv2 = up_q ? 12'sd2 : -12'sd2;
	assign paddr = idx_q[PA_W-1:0];

	// particle memory
	always_comb begin
		pwe    = 1'b0;
		pwdata = '{x: x_q, y: y_q, spin: item_q.place_spin, wx: 16'sd0, wy: 16'sd0};
		if (state_q == S_SLAT && item_q.opcode == aipu_pkg::OP_PLACE)
			pwe = 1'b1;
		if (state_q == S_FIN) begin
			pwe    = 1'b1;
			pwdata = '{x: nx_q, y: ny_q, spin: up_q, wx: wx_q, wy: wy_q};
		end
	end

	always_ff @(posedge clk) begin
		if (pwe)
			pmem[paddr] <= pwdata;
		prd_q <= pmem[paddr];
	end

	// site memory
	assign sraddr = (state_q == S_NRD) ? site_of(nx_q, ny_q) : site_of(x_q, y_q);

	always_comb begin
		swe    = 1'b0;
		swaddr = site_of(x_q, y_q);
		swdata = '{mag: srd_q.mag + sv, dens: srd_q.dens + 11'd1};
		case (state_q)
			S_CLEAR: begin
				swe    = 1'b1;
				swaddr = clr_q;
				swdata = '0;
			end
			S_SLAT: begin
				swe    = (item_q.opcode == aipu_pkg::OP_PLACE);
				swdata = '{mag: srd_q.mag + (item_q.place_spin ? 12'sd1 : -12'sd1),
					dens: srd_q.dens + 11'd1};
			end
			S_MOVE: begin
				swe    = (act_q != aipu_pkg::ACT_NONE);
				swdata = (act_q == aipu_pkg::ACT_FLIP) ? '{mag: m_q - sv2, dens: rho_q}
					: '{mag: m_q - sv, dens: rho_q - 11'd1};
			end
			S_NLAT: begin
				swe    = 1'b1;
				swaddr = site_of(nx_q, ny_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (swe)
			smem[swaddr] <= swdata;
		srd_q <= smem[sraddr];
	end

	// thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off1_q <= '0;
			off2_q <= '0;
			off3_q <= '0;
			off4_q <= '0;
		end else begin
			off1_q <= 35'(cfg.diffusion_dt);
			off2_q <= 35'(cfg.diffusion_dt) * 35'd2 + 35'(cfg.drive_dt);
			off3_q <= 35'(cfg.diffusion_dt) * 35'd3 + 35'(cfg.drive_dt);
			off4_q <= 35'(cfg.diffusion_dt) * 35'd4 + 35'(cfg.drive_dt);
		end
	end

	assign t1e    = 36'(t1);
	assign draw_e = 36'(item_q.uniform_draw);

	always_comb begin
		if (draw_e < t1e)
			act_d = aipu_pkg::ACT_FLIP;
		else if (draw_e < t1e + 36'(off1_q))
			act_d = aipu_pkg::ACT_HOP_AGAINST;
		else if (draw_e < t1e + 36'(off2_q))
			act_d = aipu_pkg::ACT_HOP_ALONG;
		else if (draw_e < t1e + 36'(off3_q))
			act_d = aipu_pkg::ACT_UP;
		else if (draw_e < t1e + 36'(off4_q))
			act_d = aipu_pkg::ACT_DOWN;
		else
			act_d = aipu_pkg::ACT_NONE;
	end

	assign rate_start = (state_q == S_SLAT) && (item_q.opcode == aipu_pkg::OP_UPDATE);
	assign dir_plus   = (act_q == aipu_pkg::ACT_HOP_ALONG) == up_q;

	aipu_rate u_rate (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rate_start),
		.m       (srd_q.mag),
		.rho     (srd_q.dens),
		.spin_up (up_q),
		.cfg     (cfg),
		.done    (rate_done),
		.t1      (t1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			item_q   <= '0;
			idx_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			nx_q     <= '0;
			ny_q     <= '0;
			up_q     <= 1'b0;
			wx_q     <= '0;
			wy_q     <= '0;
			m_q      <= '0;
			rho_q    <= '0;
			total_q  <= '0;
			act_q    <= aipu_pkg::ACT_NONE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SA_W'(SITES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						item_q  <= item;
						idx_q   <= IDXR_W'(item.particle_index);
						x_q     <= {1'b0, item.place_x};
						y_q     <= {1'b0, item.place_y};
						up_q    <= item.place_spin;
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					if (17'(idx_q) >= 17'(MAX_PARTICLES))
						idx_q <= IDXR_W'(17'(idx_q) - 17'(MAX_PARTICLES));
					else
						state_q <= (item_q.opcode == aipu_pkg::OP_PLACE) ? S_MOD : S_PRD;
				end
				S_PRD: state_q <= S_PLAT;
				S_PLAT: begin
					x_q     <= prd_q.x;
					y_q     <= prd_q.y;
					up_q    <= prd_q.spin;
					wx_q    <= prd_q.wx;
					wy_q    <= prd_q.wy;
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (x_q >= w_eff)
						x_q <= x_q - w_eff;
					else if (y_q >= h_eff)
						y_q <= y_q - h_eff;
					else
						state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SLAT;
				S_SLAT: begin
					m_q   <= srd_q.mag;
					rho_q <= srd_q.dens;
					if (item_q.opcode == aipu_pkg::OP_PLACE) begin
						total_q <= total_q + (item_q.place_spin ? 12'sd1 : -12'sd1);
						result_q <= '{action: aipu_pkg::ACT_PLACED, new_x: x_q[5:0],
							new_y: y_q[5:0], new_spin: item_q.place_spin,
							winding_x: 16'sd0, winding_y: 16'sd0,
							total_magnetization: total_q
								+ (item_q.place_spin ? 12'sd1 : -12'sd1)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					if (rate_done)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					act_q   <= act_d;
					nx_q    <= x_q;
					ny_q    <= y_q;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					state_q <= S_NRD;
					case (act_q)
						aipu_pkg::ACT_FLIP: begin
							up_q    <= ~up_q;
							total_q <= total_q - sv2;
							state_q <= S_FIN;
						end
						aipu_pkg::ACT_HOP_AGAINST, aipu_pkg::ACT_HOP_ALONG: begin
							if (dir_plus) begin
								if (8'(x_q) + 8'd1 >= 8'(w_eff)) begin
									nx_q <= '0;
									wx_q <= sat_inc(wx_q);
								end else begin
									nx_q <= x_q + 7'd1;
								end
							end else if (x_q == '0) begin
								nx_q <= w_eff - 7'd1;
								wx_q <= sat_dec(wx_q);
							end else begin
								nx_q <= x_q - 7'd1;
							end
						end
						aipu_pkg::ACT_UP: begin
							if (8'(y_q) + 8'd1 >= 8'(h_eff)) begin
								ny_q <= '0;
								wy_q <= sat_inc(wy_q);
							end else begin
								ny_q <= y_q + 7'd1;
							end
						end
						aipu_pkg::ACT_DOWN: begin
							if (y_q == '0) begin
								ny_q <= h_eff - 7'd1;
								wy_q <= sat_dec(wy_q);
							end else begin
								ny_q <= y_q - 7'd1;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_NRD: state_q <= S_NLAT;
				S_NLAT: state_q <= S_FIN;
				S_FIN: begin
					result_q <= '{action: act_q, new_x: nx_q[5:0], new_y: ny_q[5:0],
						new_spin: up_q, winding_x: wx_q, winding_y: wy_q,
						total_magnetization: total_q};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/core/aipu_check.sv */
// Port-level checker for the active Ising particle update block.
`timescale 1ns / 1ps
module aipu_check (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input aipu_pkg::result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held over two cycles");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in flight");

	a_place_winding: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.action == aipu_pkg::ACT_PLACED
		|-> result.winding_x == 16'sd0 && result.winding_y == 16'sd0)
		else $error("placed particle with nonzero winding");

endmodule

bind active_ising_particle_update_top aipu_check u_aipu_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
